// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies consequent
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m failed");

`endif

// ===== rtl/core/lrp_pkg.sv =====
`timescale 1ns / 1ps

package lrp_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int PAGE_W      = 16;
  localparam int CAP_W       = 5;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [PAGE_W-1:0] NO_PAGE   = '1;
  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(10);

  // register index decoded from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // operation codes
  localparam logic FUNC_TOUCH = 1'b0;
  localparam logic FUNC_EVICT = 1'b1;

  // per-cell control from the top level
  typedef struct packed {
    logic load;   // a word is accepted this cycle
    logic valid;  // cell lies below the occupancy
    logic tail;   // cell holds the least recent page
    logic full;   // occupancy has reached the capacity
  } cell_ctrl_t;

  // signals that ripple from cell to cell
  typedef struct packed {
    logic              go;         // shift zone reaches the next cell
    logic              hit;        // a match was seen so far
    logic [PAGE_W-1:0] tail_data;  // least recent page found so far
  } cell_link_t;

endpackage

// ===== rtl/core/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// channel   signals                                          direction
// input     in_valid, in_ready, func, page_id                 in
// output    out_valid, out_ready, hit, evicted_valid,
//           evicted_id                                        out
// config    psel, penable, pwrite, paddr, pwdata, prdata,
//           pready                                            in / out
//
// one word per cycle while no result is stalled: all cells compare and shift in the accept cycle,
// the rate set by the ripple through the row of sixteen cells.
// the result is registered and shows the cycle after the accept.
// a stalled result holds, and a new word is taken in the same cycle the
// held one leaves.
// rst clears occupancy, the output valid and sets capacity to 10.

module lru_page_replacement import lrp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [PAGE_W-1:0] page_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic              evicted_valid,
  output logic [PAGE_W-1:0] evicted_id,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CAP_W-1:0] capacity;
  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;
  logic [OCC_W-1:0] eff_cap;
  logic             accept;
  logic             touch;
  logic             full;
  logic             ev_valid;

  cell_ctrl_t        ctrl  [MAX_ENTRIES];
  cell_link_t        link  [MAX_ENTRIES+1];
  logic [PAGE_W-1:0] entry [MAX_ENTRIES];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // clamp capacity to the legal range
  always_comb begin
    if (capacity == '0) begin
      eff_cap = OCC_W'(1);
    end else if (32'(capacity) > 32'(MAX_ENTRIES)) begin
      eff_cap = OCC_W'(MAX_ENTRIES);
    end else begin
      eff_cap = OCC_W'(capacity);
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign touch    = (func == FUNC_TOUCH);
  assign full     = (occupancy >= eff_cap);

  // row of cells
  assign link[0].go        = touch;
  assign link[0].hit       = 1'b0;
  assign link[0].tail_data = NO_PAGE;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign ctrl[i].load  = accept;
    assign ctrl[i].valid = (occupancy > OCC_W'(i));
    assign ctrl[i].tail  = (occupancy == OCC_W'(i + 1));
    assign ctrl[i].full  = full;

    lrp_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .page       (page_id),
      .prev_entry ((i == 0) ? page_id : entry[(i == 0) ? 0 : i - 1]),
      .link_in    (link[i]),
      .entry      (entry[i]),
      .link_out   (link[i+1])
    );
  end

  // occupancy update and drop decision
  always_comb begin
    occupancy_next = occupancy;
    ev_valid       = 1'b0;
    if (func == FUNC_EVICT) begin
      if (occupancy != '0) begin
        occupancy_next = occupancy - OCC_W'(1);
        ev_valid       = 1'b1;
      end
    end else if (!link[MAX_ENTRIES].hit) begin
      if (full) begin
        ev_valid = 1'b1;
      end else begin
        occupancy_next = occupancy + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept) begin
      occupancy <= occupancy_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit           <= touch && link[MAX_ENTRIES].hit;
      evicted_valid <= ev_valid;
      evicted_id    <= ev_valid ? link[MAX_ENTRIES].tail_data : NO_PAGE;
    end
  end

endmodule

// ===== rtl/core/lrp_cell.sv =====
`timescale 1ns / 1ps

module lrp_cell import lrp_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [PAGE_W-1:0] page,
  input  logic [PAGE_W-1:0] prev_entry,
  input  cell_link_t        link_in,
  output logic [PAGE_W-1:0] entry,
  output cell_link_t        link_out
);

  logic match;

  // compare against the touched page
  assign match = ctrl.valid && (entry == page);

  // the shift stops at a match, at a dropped tail or at the first empty cell
  assign link_out.go = link_in.go && ctrl.valid && !match && !(ctrl.full && ctrl.tail);
  assign link_out.hit = link_in.hit || match;
  assign link_out.tail_data = ctrl.tail ? entry : link_in.tail_data;

  // take the neighbor's page when inside the shift zone
  always_ff @(posedge clk) begin
    if (ctrl.load && link_in.go) begin
      entry <= prev_entry;
    end
  end

endmodule

// ===== rtl/core/lrp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrp_checker import lrp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              hit,
  input logic              evicted_valid,
  input logic [PAGE_W-1:0] evicted_id
);

  // a stalled result holds its word
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(evicted_id))

  // no new word while a result is stalled
  `ASSERT_IMPLY(a_no_take_stalled, clk, rst, out_valid && !out_ready, !in_ready)

  // a hit never drops a page
  `ASSERT_IMPLY(a_hit_no_drop, clk, rst, out_valid && hit, !evicted_valid)

  // every accepted word brings a result in the next cycle
  `ASSERT_NEXT(a_result_follows, clk, rst, in_valid && in_ready, out_valid)

  // no drop shows the empty page code
  `ASSERT_IMPLY(a_no_drop_code, clk, rst, out_valid && !evicted_valid, evicted_id == NO_PAGE)

endmodule

bind lru_page_replacement lrp_checker u_lrp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_id    (evicted_id)
);

// ===== bench/lru_page_replacement_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_tb;
  import lrp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;
  localparam int PHASE_ITEMS = 193;
  localparam int PHASE_CAPS [10] = '{16, 1, 31, 0, 17, 4, 2, 12, 7, 16};
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] page;
  } access_t;

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_id;
  } lru_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_TOUCH;
  logic [PAGE_W-1:0] page_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic              evicted_valid;
  logic [PAGE_W-1:0] evicted_id;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lru_page_replacement u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .page_id       (page_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_id    (evicted_id),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // shadow copy of the recency stack, entry 0 most recent
  logic [PAGE_W-1:0] shadow_stack [MAX_ENTRIES];
  int unsigned       shadow_count = 0;
  logic [CAP_W-1:0]  shadow_capacity = CAP_RESET;

  access_t     pending_accesses [$];
  lru_result_t predicted_results [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  access_t     next_access;
  lru_result_t want;

  // lookup, reorder and drop on the shadow stack, returns the result word
  function automatic lru_result_t apply_access(input access_t acc);
    lru_result_t res;
    int unsigned limit;
    int unsigned found;
    int unsigned i;
    res.hit = 1'b0;
    res.evicted_valid = 1'b0;
    res.evicted_id = NO_PAGE;
    if (shadow_capacity == 0)
      limit = 1;
    else if (shadow_capacity > MAX_ENTRIES)
      limit = MAX_ENTRIES;
    else
      limit = 32'(shadow_capacity);
    if (acc.op == FUNC_EVICT) begin
      if (shadow_count > 0) begin
        shadow_count--;
        res.evicted_valid = 1'b1;
        res.evicted_id = shadow_stack[shadow_count];
      end
    end else begin
      found = shadow_count;
      for (i = 0; i < shadow_count; i++)
        if (found == shadow_count && shadow_stack[i] == acc.page)
          found = i;
      if (found < shadow_count) begin
        res.hit = 1'b1;
        for (i = found; i > 0; i--)
          shadow_stack[i] = shadow_stack[i-1];
        shadow_stack[0] = acc.page;
      end else begin
        // full (or over a lowered capacity): drop the least recent first
        if (shadow_count >= limit) begin
          shadow_count--;
          res.evicted_valid = 1'b1;
          res.evicted_id = shadow_stack[shadow_count];
        end
        for (i = shadow_count; i > 0; i--)
          if (i < MAX_ENTRIES)
            shadow_stack[i] = shadow_stack[i-1];
        shadow_stack[0] = acc.page;
        shadow_count++;
      end
    end
    return res;
  endfunction

  // input driver with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predicted_results.insert(predicted_results.size(),
                                 apply_access('{op: func, page: page_id}));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          send_gap = $urandom_range(0, 5);
        end else if (pending_accesses.size() > 0) begin
          next_access = pending_accesses.pop_front();
          in_valid <= 1'b1;
          func <= next_access.op;
          page_id <= next_access.page;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls plus an occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_done != hold_requests) begin
      out_ready <= 1'b0;
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected word hit=%0b evicted_valid=%0b evicted_id=%h",
                 $time, hit, evicted_valid, evicted_id);
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
          error_count++;
        end
        if (evicted_valid !== want.evicted_valid) begin
          $display("%0t: evicted_valid expected %0b actual %0b",
                   $time, want.evicted_valid, evicted_valid);
          error_count++;
        end
        if (evicted_id !== want.evicted_id) begin
          $display("%0t: evicted_id expected %h actual %h",
                   $time, want.evicted_id, evicted_id);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_access(input logic op, input logic [PAGE_W-1:0] page);
    pending_accesses.insert(pending_accesses.size(), '{op: op, page: page});
  endtask

  // block idle: nothing queued, offered or outstanding
  task automatic wait_idle();
    while (pending_accesses.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  // apb write of the capacity register
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_capacity = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    int phase;
    int n;
    int cap;
    int span;
    int evict_pct;
    int r;
    logic [PAGE_W-1:0] page_pool [20];

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset capacity: empty evict, field extremes, hit, fill and drop
    queue_access(FUNC_EVICT, 16'hFFFF);
    queue_access(FUNC_TOUCH, 16'h0000);
    queue_access(FUNC_TOUCH, 16'hFFFF);
    queue_access(FUNC_TOUCH, 16'hAAAA);
    queue_access(FUNC_TOUCH, 16'h5555);
    queue_access(FUNC_TOUCH, 16'hFFFF);
    queue_access(FUNC_EVICT, 16'h0000);
    for (n = 1; n <= 7; n++)
      queue_access(FUNC_TOUCH, 16'(n));
    queue_access(FUNC_TOUCH, 16'h8000);
    wait_idle();

    // capacity lowered under the occupancy
    write_capacity(5'd3);
    queue_access(FUNC_TOUCH, 16'h1234);
    queue_access(FUNC_TOUCH, 16'h0007);
    queue_access(FUNC_EVICT, 16'h5A5A);
    wait_idle();

    // zero capacity acts as one
    write_capacity(5'd0);
    queue_access(FUNC_TOUCH, 16'h4321);
    wait_idle();

    // capacity over the stack depth
    write_capacity(5'd31);
    queue_access(FUNC_TOUCH, 16'h0F0F);
    wait_idle();

    // random phases, one capacity each
    for (phase = 0; phase < 10; phase++) begin
      cap = (phase == 9) ? $urandom_range(0, 31) : PHASE_CAPS[phase];
      write_capacity(CAP_W'(cap));
      span = (cap == 0) ? 1 : (cap > MAX_ENTRIES ? MAX_ENTRIES : cap);
      span = span + 4;
      for (n = 0; n < 20; n++)
        page_pool[n] = PAGE_W'($urandom_range(0, 65535));
      calm = (phase % 3 == 2) || (phase == 9);
      evict_pct = (phase % 2 == 1) ? 30 : 8;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < evict_pct)
          queue_access(FUNC_EVICT, PAGE_W'($urandom_range(0, 65535)));
        else if (r < evict_pct + 6)
          queue_access(FUNC_TOUCH, PAGE_W'($urandom_range(0, 65535)));
        else
          queue_access(FUNC_TOUCH, page_pool[$urandom_range(0, span - 1)]);
      end
      // long output hold while words keep coming
      if (phase == 3)
        hold_requests++;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, predicted_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
